@@ rtl/lesf_pkg.sv @@
package lesf_pkg;

   // grid limits
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;

   // derived widths
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int SIZE_W = COL_W + 1;
   localparam int CODE_W = 8;

   // stream and register port widths
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // result queue
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   // register reset values
   localparam logic [CODE_W-1:0] OBSTACLE_RESET = 8'd111;
   localparam logic [CODE_W-1:0] EMPTY_RESET    = 8'd46;
   localparam logic [SIZE_W-1:0] WIDTH_RESET    = SIZE_W'(1);

   // register indexes (word address bits)
   typedef enum logic [1:0] {
      CSR_OBSTACLE = 2'd0,
      CSR_EMPTY    = 2'd1,
      CSR_WIDTH    = 2'd2
   } csr_index_type;

   // one finished map result
   typedef struct packed {
      logic              bad;
      logic [COL_W-1:0]  col;
      logic [ROW_W-1:0]  row;
      logic [SIZE_W-1:0] size;
   } result_type;

endpackage

@@ rtl/lesf_ram.sv @@
module lesf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/largest_empty_square_finder.sv @@
// result path: a map result runs through stage 1, stage 2 and the result queue to rsp
// throughput: one cell per cycle while the result queue has room, set by the row buffer
//   read-modify-write loop (read at accept, write back in the next cycle, same-column overlap forwarded)
// reset: registers return to their defaults, counters, best square and queue clear;
//   the row buffer is not cleared and is only read in rows after it was written
module largest_empty_square_finder
   import lesf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // cell input
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [7:0] cell_code
   input  logic                  req_tlast,   // last_cell
   // map result
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [10:0] best_size, [20:11] best_row,
                                              // [30:21] best_col, [31] zero
   output logic                  rsp_tuser,   // bad_cell_seen
   // register port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   // configuration registers
   logic [CODE_W-1:0] obstacle_ff, obstacle_in;
   logic [CODE_W-1:0] empty_ff, empty_in;
   logic [SIZE_W-1:0] width_ff, width_in;
   csr_index_type     csr_index;
   logic              csr_write;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_index_type'(csr_paddr[3:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      obstacle_in = obstacle_ff;
      empty_in    = empty_ff;
      width_in    = width_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_OBSTACLE: obstacle_in = csr_pwdata[CODE_W-1:0];
            CSR_EMPTY:    empty_in    = csr_pwdata[CODE_W-1:0];
            CSR_WIDTH:    width_in    = csr_pwdata[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         CSR_OBSTACLE: csr_prdata = CSR_DATA_W'(obstacle_ff);
         CSR_EMPTY:    csr_prdata = CSR_DATA_W'(empty_ff);
         CSR_WIDTH:    csr_prdata = CSR_DATA_W'(width_ff);
         default:      csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         obstacle_ff <= OBSTACLE_RESET;
         empty_ff    <= EMPTY_RESET;
         width_ff    <= WIDTH_RESET;
      end else begin
         obstacle_ff <= obstacle_in;
         empty_ff    <= empty_in;
         width_ff    <= width_in;
      end
   end

   // ---------------------------------------------------------------
   // stage 0: accept, position counters, row buffer read
   // ---------------------------------------------------------------
   logic              req_accept;
   logic [CODE_W-1:0] cell_code;
   logic [SIZE_W-1:0] width_eff;
   logic [SIZE_W-1:0] col_next;
   logic [ROW_W:0]    row_next;
   logic              row_end;
   logic [COL_W-1:0]  col_index_ff, col_index_in;
   logic [ROW_W-1:0]  row_index_ff, row_index_in;

   assign req_accept = req_tvalid && req_tready;
   assign cell_code  = req_tdata[CODE_W-1:0];

   // out-of-range widths clamp to 1 .. MAX_WIDTH
   always_comb begin
      if (width_ff == '0) begin
         width_eff = SIZE_W'(1);
      end else if (width_ff > SIZE_W'(MAX_WIDTH)) begin
         width_eff = SIZE_W'(MAX_WIDTH);
      end else begin
         width_eff = width_ff;
      end
   end

   assign col_next = {1'b0, col_index_ff} + SIZE_W'(1);
   assign row_next = {1'b0, row_index_ff} + (ROW_W + 1)'(1);
   assign row_end  = col_next >= width_eff;

   always_comb begin
      col_index_in = col_index_ff;
      row_index_in = row_index_ff;
      if (req_accept) begin
         if (req_tlast) begin
            col_index_in = '0;
            row_index_in = '0;
         end else if (row_end) begin
            col_index_in = '0;
            if (row_next < (ROW_W + 1)'(MAX_HEIGHT)) begin
               row_index_in = row_next[ROW_W-1:0];
            end
         end else begin
            col_index_in = col_next[COL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_index_ff <= '0;
         row_index_ff <= '0;
      end else begin
         col_index_ff <= col_index_in;
         row_index_ff <= row_index_in;
      end
   end

   // ---------------------------------------------------------------
   // stage 1: size of the square ending at the cell, write back
   // ---------------------------------------------------------------
   logic              s1_valid_ff;
   logic [COL_W-1:0]  s1_col_ff;
   logic [ROW_W-1:0]  s1_row_ff;
   logic              s1_obst_ff;
   logic              s1_bad_ff;
   logic              s1_last_ff;
   logic              s1_clr_ff;
   logic              s1_fwd_ff;
   logic [SIZE_W-1:0] s1_fwd_data_ff;
   logic [SIZE_W-1:0] rd_data;
   logic [SIZE_W-1:0] s1_up;
   logic [SIZE_W-1:0] s1_min_a;
   logic [SIZE_W-1:0] s1_min;
   logic [SIZE_W-1:0] s1_size;
   logic [SIZE_W-1:0] left_ff, left_in;
   logic [SIZE_W-1:0] diag_ff, diag_in;

   lesf_ram #(
      .WIDTH (SIZE_W),
      .DEPTH (MAX_WIDTH)
   ) u_row_buf (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data (s1_size),
      .rd_addr (col_index_ff),
      .rd_data (rd_data)
   );

   // stage 1 control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_accept;
      end
   end

   // stage 1 payload; forward the write that overlaps this read
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_col_ff      <= col_index_ff;
         s1_row_ff      <= row_index_ff;
         s1_obst_ff     <= cell_code == obstacle_ff;
         s1_bad_ff      <= (cell_code != obstacle_ff) && (cell_code != empty_ff);
         s1_last_ff     <= req_tlast;
         s1_clr_ff      <= req_tlast || row_end;
         s1_fwd_ff      <= s1_valid_ff && (s1_col_ff == col_index_ff);
         s1_fwd_data_ff <= s1_size;
      end
   end

   // upper neighbor from the row buffer, none in the first row
   always_comb begin
      if (s1_row_ff == '0) begin
         s1_up = '0;
      end else if (s1_fwd_ff) begin
         s1_up = s1_fwd_data_ff;
      end else begin
         s1_up = rd_data;
      end
   end

   assign s1_min_a = (left_ff < s1_up) ? left_ff : s1_up;
   assign s1_min   = (diag_ff < s1_min_a) ? diag_ff : s1_min_a;

   always_comb begin
      if (s1_obst_ff) begin
         s1_size = '0;
      end else if ((s1_row_ff == '0) || (s1_col_ff == '0)) begin
         s1_size = SIZE_W'(1);
      end else begin
         s1_size = s1_min + SIZE_W'(1);
      end
   end

   // left and upper-left neighbors, cleared at row end and map end
   always_comb begin
      left_in = left_ff;
      diag_in = diag_ff;
      if (s1_valid_ff) begin
         if (s1_clr_ff) begin
            left_in = '0;
            diag_in = '0;
         end else begin
            left_in = s1_size;
            diag_in = s1_up;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
         diag_ff <= '0;
      end else begin
         left_ff <= left_in;
         diag_ff <= diag_in;
      end
   end

   // ---------------------------------------------------------------
   // stage 2: best square tracking, result on the last cell
   // ---------------------------------------------------------------
   logic              s2_valid_ff;
   logic [SIZE_W-1:0] s2_size_ff;
   logic [ROW_W-1:0]  s2_row_ff;
   logic [COL_W-1:0]  s2_col_ff;
   logic              s2_bad_ff;
   logic              s2_last_ff;
   logic [SIZE_W-1:0] best_side_ff, best_side_in;
   logic [ROW_W-1:0]  best_top_ff, best_top_in;
   logic [COL_W-1:0]  best_left_ff, best_left_in;
   logic              bad_ff, bad_in;
   logic [ROW_W:0]    s2_row_p1;
   logic [COL_W:0]    s2_col_p1;
   logic [ROW_W:0]    s2_top;
   logic [COL_W:0]    s2_left;
   logic              s2_better;
   result_type        s2_result;
   logic              fifo_push;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         s2_size_ff <= s1_size;
         s2_row_ff  <= s1_row_ff;
         s2_col_ff  <= s1_col_ff;
         s2_bad_ff  <= s1_bad_ff;
         s2_last_ff <= s1_last_ff;
      end
   end

   // corner of the square, floored at zero
   assign s2_row_p1 = {1'b0, s2_row_ff} + (ROW_W + 1)'(1);
   assign s2_col_p1 = {1'b0, s2_col_ff} + (COL_W + 1)'(1);
   assign s2_top    = (s2_row_p1 >= (ROW_W + 1)'(s2_size_ff)) ?
                      s2_row_p1 - (ROW_W + 1)'(s2_size_ff) : '0;
   assign s2_left   = (s2_col_p1 >= (COL_W + 1)'(s2_size_ff)) ?
                      s2_col_p1 - (COL_W + 1)'(s2_size_ff) : '0;
   assign s2_better = s2_size_ff > best_side_ff;

   // first strictly larger square wins
   always_comb begin
      s2_result.size = best_side_ff;
      s2_result.row  = best_top_ff;
      s2_result.col  = best_left_ff;
      s2_result.bad  = bad_ff || s2_bad_ff;
      if (s2_better) begin
         s2_result.size = s2_size_ff;
         s2_result.row  = s2_top[ROW_W-1:0];
         s2_result.col  = s2_left[COL_W-1:0];
      end
   end

   assign fifo_push = s2_valid_ff && s2_last_ff;

   always_comb begin
      best_side_in = best_side_ff;
      best_top_in  = best_top_ff;
      best_left_in = best_left_ff;
      bad_in       = bad_ff;
      if (s2_valid_ff) begin
         if (s2_last_ff) begin
            best_side_in = '0;
            best_top_in  = '0;
            best_left_in = '0;
            bad_in       = 1'b0;
         end else begin
            best_side_in = s2_result.size;
            best_top_in  = s2_result.row;
            best_left_in = s2_result.col;
            bad_in       = s2_result.bad;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_side_ff <= '0;
         best_top_ff  <= '0;
         best_left_ff <= '0;
         bad_ff       <= 1'b0;
      end else begin
         best_side_ff <= best_side_in;
         best_top_ff  <= best_top_in;
         best_left_ff <= best_left_in;
         bad_ff       <= bad_in;
      end
   end

   // ---------------------------------------------------------------
   // result queue; input is held back only when the queue plus the
   // last cells still in flight could overflow it
   // ---------------------------------------------------------------
   result_type            fifo_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0] count_ff, count_in;
   logic [FIFO_CNT_W-1:0] pending;
   logic                  fifo_pop;
   result_type            head;

   assign pending  = FIFO_CNT_W'(s1_valid_ff && s1_last_ff)
                   + FIFO_CNT_W'(s2_valid_ff && s2_last_ff);
   assign req_tready = (count_ff + pending) < FIFO_CNT_W'(FIFO_DEPTH);

   assign fifo_pop   = rsp_tvalid && rsp_tready;
   assign head       = fifo_ff[rd_ptr_ff];
   assign rsp_tvalid = count_ff != '0;
   assign rsp_tdata  = {1'b0, head.col, head.row, head.size};
   assign rsp_tuser  = head.bad;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (fifo_push) begin
         wr_ptr_in = wr_ptr_ff + FIFO_PTR_W'(1);
      end
      if (fifo_pop) begin
         rd_ptr_in = rd_ptr_ff + FIFO_PTR_W'(1);
      end
      if (fifo_push && !fifo_pop) begin
         count_in = count_ff + FIFO_CNT_W'(1);
      end else if (!fifo_push && fifo_pop) begin
         count_in = count_ff - FIFO_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fifo_push) begin
         fifo_ff[wr_ptr_ff] <= s2_result;
      end
   end

   // ---------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------
   a_queue_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (fifo_push && !fifo_pop) |-> (count_ff < FIFO_CNT_W'(FIFO_DEPTH)))
      else $error("result queue overflow");

   a_queue_reserved: assert property (@(posedge clock) disable iff (reset)
      (count_ff + pending) <= FIFO_CNT_W'(FIFO_DEPTH))
      else $error("in-flight results exceed queue room");

   a_map_restart: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_tlast) |=> (col_index_ff == '0) && (row_index_ff == '0))
      else $error("position not cleared after last cell");

   a_best_cleared: assert property (@(posedge clock) disable iff (reset)
      fifo_push |=> (best_side_ff == '0) && !bad_ff)
      else $error("best square not cleared after result");

   a_row_end_wrap: assert property (@(posedge clock) disable iff (reset)
      (req_accept && row_end) |=> (col_index_ff == '0))
      else $error("column did not wrap at row end");

endmodule

@@ tb/largest_empty_square_finder_tb.sv @@
module largest_empty_square_finder_tb;
   import lesf_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int HOLD_CYCLES  = 300;
   localparam int SETTLE       = 8;
   localparam int RANDOM_CELLS = 250;
   localparam logic [CODE_W-1:0] DOT  = EMPTY_RESET;
   localparam logic [CODE_W-1:0] RING = OBSTACLE_RESET;
   localparam logic [CODE_W-1:0] JUNK = 8'h78;

   // directed stimulus rows
   typedef enum logic {
      STEP_CSR,
      STEP_CELLS
   } step_kind_type;

   typedef struct {
      step_kind_type     kind;
      csr_index_type     reg_sel;
      logic [31:0]       wdata;
      logic [CODE_W-1:0] code;
      int                count;
      bit                last;
      bit                typed;
      result_type        want;
   } step_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // register copy
   logic [CODE_W-1:0] blocked_code;
   logic [CODE_W-1:0] open_code;
   logic [SIZE_W-1:0] width_reg;

   // square tracker state
   logic [SIZE_W-1:0] row_buf [MAX_WIDTH];
   logic [SIZE_W-1:0] left_run;
   logic [SIZE_W-1:0] diag_run;
   logic [COL_W-1:0]  col_pos;
   logic [ROW_W-1:0]  row_pos;
   logic [SIZE_W-1:0] best_len;
   logic [ROW_W-1:0]  best_top;
   logic [COL_W-1:0]  best_left;
   logic              bad_seen;

   result_type square_q [$];
   step_type   plan_q [$];
   int         errors;
   int         cycles;
   bit         reset_done;
   bit         hold_request;
   bit         tx_gaps_on;
   bit         rx_gaps_on;

   largest_empty_square_finder u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // clear the per-map state, the row buffer keeps its contents
   function automatic void clear_map();
      left_run  = '0;
      diag_run  = '0;
      col_pos   = '0;
      row_pos   = '0;
      best_len  = '0;
      best_top  = '0;
      best_left = '0;
      bad_seen  = 1'b0;
   endfunction

   // fold one cell into the square search, report the map result on its last cell
   task automatic fold_cell(input logic [CODE_W-1:0] code, input logic last,
                            output bit done, output result_type res);
      int w;
      int c;
      int r;
      int up;
      int sz;
      int m;
      w = width_reg;
      if (w < 1) w = 1;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      c = col_pos;
      r = row_pos;
      if (code != open_code && code != blocked_code) bad_seen = 1'b1;
      up = (r != 0) ? int'(row_buf[c]) : 0;
      if (code == blocked_code) begin
         sz = 0;
      end else if (r == 0 || c == 0) begin
         sz = 1;
      end else begin
         m = left_run;
         if (up < m) m = up;
         if (diag_run < m) m = diag_run;
         sz = m + 1;
      end
      // first square of a given size wins
      if (sz > best_len) begin
         best_len  = SIZE_W'(sz);
         best_top  = (r + 1 >= sz) ? ROW_W'(r + 1 - sz) : '0;
         best_left = (c + 1 >= sz) ? COL_W'(c + 1 - sz) : '0;
      end
      row_buf[c] = SIZE_W'(sz);
      diag_run   = SIZE_W'(up);
      left_run   = SIZE_W'(sz);
      // row wrap, row count saturates
      if (c + 1 >= w) begin
         col_pos  = '0;
         left_run = '0;
         diag_run = '0;
         if (r + 1 < MAX_HEIGHT) row_pos = ROW_W'(r + 1);
      end else begin
         col_pos = COL_W'(c + 1);
      end
      done     = last;
      res.size = best_len;
      res.row  = best_top;
      res.col  = best_left;
      res.bad  = bad_seen;
      if (last) clear_map();
   endtask

   // wait until all results are back and the pipeline has drained
   task automatic wait_idle();
      req_tvalid = 1'b0;
      while (square_q.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   // apb read, compared with the register copy
   task automatic csr_read_check(input csr_index_type idx);
      logic [CSR_DATA_W-1:0] want;
      logic [CSR_DATA_W-1:0] got;
      case (idx)
         CSR_OBSTACLE: want = CSR_DATA_W'(blocked_code);
         CSR_EMPTY:    want = CSR_DATA_W'(open_code);
         default:      want = CSR_DATA_W'(width_reg);
      endcase
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = CSR_ADDR_W'({idx, 2'b00});
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      got = csr_prdata;
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      if (got !== want) begin
         $error("csr_prdata[%0d] expected %0h got %0h", idx, want, got);
         errors++;
      end
   endtask

   // apb write, then read back
   task automatic csr_write(input csr_index_type idx, input logic [31:0] val);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata  = val;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         CSR_OBSTACLE: blocked_code = val[CODE_W-1:0];
         CSR_EMPTY:    open_code    = val[CODE_W-1:0];
         default:      width_reg    = val[SIZE_W-1:0];
      endcase
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_read_check(idx);
   endtask

   // one cell transaction; a typed result replaces the computed one
   task automatic push_cell(input logic [CODE_W-1:0] code, input logic last,
                            input bit typed, input result_type want);
      int         gap;
      bit         done;
      result_type res;
      gap = tx_gaps_on ? $urandom_range(0, 14) : 0;
      repeat (gap) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = code;
      req_tlast  = last;
      do @(posedge clock); while (!req_tready);
      fold_cell(code, last, done, res);
      if (done) square_q.push_back(typed ? want : res);
      @(negedge clock);
   endtask

   function automatic void add_csr(input csr_index_type idx, input logic [31:0] val);
      step_type s;
      s.kind    = STEP_CSR;
      s.reg_sel = idx;
      s.wdata   = val;
      s.code    = '0;
      s.count   = 0;
      s.last    = 1'b0;
      s.typed   = 1'b0;
      s.want    = '0;
      plan_q.push_back(s);
   endfunction

   function automatic void add_run(input logic [CODE_W-1:0] code, input int count,
                                   input bit last);
      step_type s;
      s.kind    = STEP_CELLS;
      s.reg_sel = CSR_OBSTACLE;
      s.wdata   = '0;
      s.code    = code;
      s.count   = count;
      s.last    = last;
      s.typed   = 1'b0;
      s.want    = '0;
      plan_q.push_back(s);
   endfunction

   // a run that closes a map with a known result
   function automatic void add_map(input logic [CODE_W-1:0] code, input int count,
                                   input int sz, input int r, input int c, input bit bad);
      add_run(code, count, 1'b1);
      plan_q[$].typed    = 1'b1;
      plan_q[$].want.size = SIZE_W'(sz);
      plan_q[$].want.row  = ROW_W'(r);
      plan_q[$].want.col  = COL_W'(c);
      plan_q[$].want.bad  = bad;
   endfunction

   // directed cases
   task automatic run_directed();
      int n;
      // single cells after reset, width 1
      add_map(DOT, 1, 1, 0, 0, 0);
      add_map(RING, 1, 0, 0, 0, 0);
      add_map(8'h00, 1, 1, 0, 0, 1);
      add_map(8'hFF, 1, 1, 0, 0, 1);
      // empty and obstacle codes equal: obstacle wins
      add_csr(CSR_EMPTY, 32'(RING));
      add_map(RING, 1, 0, 0, 0, 0);
      add_csr(CSR_EMPTY, 32'(DOT));
      // full 4x4 empty grid
      add_csr(CSR_WIDTH, 32'd4);
      add_map(DOT, 16, 4, 0, 0, 0);
      // tie of equal squares, the first one is kept
      add_csr(CSR_WIDTH, 32'd3);
      add_run(DOT, 1, 1'b0);
      add_run(RING, 1, 1'b0);
      add_map(DOT, 1, 1, 0, 0, 0);
      // width shrinks in the middle of a row
      add_csr(CSR_WIDTH, 32'd6);
      add_run(DOT, 4, 1'b0);
      add_csr(CSR_WIDTH, 32'd2);
      add_run(JUNK, 6, 1'b1);
      // zero width acts as one column
      add_csr(CSR_WIDTH, 32'd0);
      add_map(DOT, 3, 1, 0, 0, 0);
      // oversized width clamps to the maximum
      add_csr(CSR_WIDTH, 32'h7FF);
      add_run(DOT, MAX_WIDTH, 1'b0);
      add_map(DOT, 3, 2, 0, 0, 0);
      // row count saturates at the last row
      add_csr(CSR_WIDTH, 32'd1);
      add_run(RING, MAX_HEIGHT + 6, 1'b0);
      add_map(DOT, 2, 1, MAX_HEIGHT - 1, 0, 0);
      // extreme character codes
      add_csr(CSR_OBSTACLE, 32'h0000_0000);
      add_csr(CSR_EMPTY, 32'h0000_00FF);
      add_csr(CSR_WIDTH, 32'd3);
      add_map(8'hFF, 9, 3, 0, 0, 0);
      add_map(8'h00, 1, 0, 0, 0, 0);

      foreach (plan_q[i]) begin
         if (plan_q[i].kind == STEP_CSR) begin
            wait_idle();
            csr_write(plan_q[i].reg_sel, plan_q[i].wdata);
         end else begin
            for (n = 0; n < plan_q[i].count; n++)
               push_cell(plan_q[i].code, plan_q[i].last && n == plan_q[i].count - 1,
                         plan_q[i].typed, plan_q[i].want);
         end
      end
   endtask

   // random maps in phases of random settings
   task automatic run_random();
      int          sent;
      int          sel;
      int          w_eff;
      int          rows;
      int          ncells;
      int          density;
      int          pick;
      bit          noisy;
      logic [31:0] wval;
      logic [CODE_W-1:0] code;
      sent = 0;
      // back pressure: receiver holds off while one-cell maps pour in
      wait_idle();
      tx_gaps_on   = 1'b0;
      hold_request = 1'b1;
      repeat (40) begin
         push_cell(CODE_W'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
         sent++;
      end
      while (sent < RANDOM_CELLS) begin
         wait_idle();
         sel = $urandom_range(0, 15);
         case (sel)
            0:       wval = 32'd0;
            1:       wval = 32'h7FF;
            2:       wval = 32'(MAX_WIDTH);
            3:       wval = 32'(MAX_WIDTH - 1);
            4, 5, 6: wval = 32'($urandom_range(13, 40));
            default: wval = 32'($urandom_range(1, 12));
         endcase
         csr_write(CSR_WIDTH, wval);
         csr_write(CSR_OBSTACLE, $urandom_range(0, 1) ? 32'(RING) : 32'($urandom_range(0, 255)));
         csr_write(CSR_EMPTY, $urandom_range(0, 1) ? 32'(DOT) : 32'($urandom_range(0, 255)));
         tx_gaps_on = $urandom_range(0, 3) != 0;
         rx_gaps_on = $urandom_range(0, 3) != 0;
         w_eff = (wval == 0) ? 1 : (wval > MAX_WIDTH) ? MAX_WIDTH : int'(wval);
         repeat ($urandom_range(2, 6)) begin
            // whole rows mostly, some maps cut short mid row
            if (w_eff > 40) begin
               ncells = $urandom_range(1, 80);
            end else begin
               rows   = $urandom_range(1, 96 / w_eff + 1);
               ncells = rows * w_eff;
               if ($urandom_range(0, 6) == 0) ncells = $urandom_range(1, ncells);
            end
            pick = $urandom_range(0, 3);
            density = (pick == 0) ? 0 : (pick == 1) ? 10 : (pick == 2) ? 30 : 60;
            noisy = $urandom_range(0, 9) == 0;
            for (int i = 0; i < ncells; i++) begin
               pick = $urandom_range(0, 99);
               if (noisy || (pick >= density && pick < density + 3))
                  code = CODE_W'($urandom_range(0, 255));
               else if (pick < density)
                  code = blocked_code;
               else
                  code = open_code;
               push_cell(code, i == ncells - 1, 1'b0, '0);
               sent++;
            end
         end
      end
   endtask

   // result side: random stalls, one long hold on request
   initial begin
      int         gap;
      result_type got;
      result_type want;
      rsp_tready = 1'b0;
      wait (reset_done);
      forever begin
         if (hold_request) begin
            rsp_tready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
         end
         gap = rx_gaps_on ? $urandom_range(0, 14) : 0;
         repeat (gap) begin
            rsp_tready = 1'b0;
            @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         got = {rsp_tuser, rsp_tdata[RSP_DATA_W-2:0]};
         if (square_q.size() == 0) begin
            $error("result transaction with no map pending");
            errors++;
         end else begin
            want = square_q.pop_front();
            if (got.size !== want.size) begin
               $error("best_size expected %0d got %0d", want.size, got.size);
               errors++;
            end
            if (got.row !== want.row) begin
               $error("best_row expected %0d got %0d", want.row, got.row);
               errors++;
            end
            if (got.col !== want.col) begin
               $error("best_col expected %0d got %0d", want.col, got.col);
               errors++;
            end
            if (got.bad !== want.bad) begin
               $error("bad_cell_seen expected %0d got %0d", want.bad, got.bad);
               errors++;
            end
            if (rsp_tdata[RSP_DATA_W-1] !== 1'b0) begin
               $error("rsp_tdata[31] expected 0 got %0b", rsp_tdata[RSP_DATA_W-1]);
               errors++;
            end
         end
         @(negedge clock);
      end
   end

   // main sequence
   initial begin
      errors       = 0;
      cycles       = 0;
      reset_done   = 1'b0;
      hold_request = 1'b0;
      tx_gaps_on   = 1'b1;
      rx_gaps_on   = 1'b1;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tlast    = 1'b0;
      csr_psel     = 1'b0;
      csr_penable  = 1'b0;
      csr_pwrite   = 1'b0;
      csr_paddr    = '0;
      csr_pwdata   = '0;
      blocked_code = OBSTACLE_RESET;
      open_code    = EMPTY_RESET;
      width_reg    = WIDTH_RESET;
      foreach (row_buf[i]) row_buf[i] = '0;
      clear_map();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset      = 1'b0;
      reset_done = 1'b1;
      @(negedge clock);
      // register defaults
      csr_read_check(CSR_OBSTACLE);
      csr_read_check(CSR_EMPTY);
      csr_read_check(CSR_WIDTH);
      run_directed();
      run_random();
      wait_idle();
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
